// File: rtl/core/assert_macros.svh
// Shared assertion helpers for the collision resolve core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a property at every clock edge outside reset.
`define CPRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a consequence in the cycle after a trigger.
`define CPRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cprc_pkg.sv
package cprc_pkg;

    localparam int unsigned POS_W       = 20;
    localparam int unsigned RAD_W       = 16;
    localparam int unsigned STF_W       = 8;
    localparam int unsigned STF_RESET   = 51;
    localparam int unsigned SQ_W        = 41;
    localparam int unsigned ROOT_W      = 21;
    localparam int unsigned OV_W        = 17;
    localparam int unsigned Q_W         = 17;
    localparam int unsigned PROD_W      = OV_W + STF_W;
    localparam int unsigned NUM_W       = 43;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned POS_MAX     = 1048575;

    typedef struct packed {
        logic [POS_W-1:0] first_x;
        logic [POS_W-1:0] first_y;
        logic [RAD_W-1:0] first_radius;
        logic [POS_W-1:0] second_x;
        logic [POS_W-1:0] second_y;
        logic [RAD_W-1:0] second_radius;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] new_first_x;
        logic [POS_W-1:0] new_first_y;
        logic [POS_W-1:0] new_second_x;
        logic [POS_W-1:0] new_second_y;
        logic             overlapped;
        logic             coincident;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] ax;
        logic [POS_W-1:0] ay;
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic             sx;
        logic             sy;
        logic [OV_W-1:0]  mx;
        logic [OV_W-1:0]  my;
        logic [OV_W-1:0]  dlen;
        logic [OV_W-1:0]  ov;
        logic             over;
        logic             coin;
    } t_job;

endpackage

// File: rtl/core/cprc_front.sv
module cprc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cprc_pkg::t_in_item i_in_data,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output cprc_pkg::t_job    o_job
);

    localparam int unsigned STAGES = cprc_pkg::ROOT_W;
    localparam int unsigned TW     = cprc_pkg::SQ_W + 1;
    localparam int unsigned PW     = cprc_pkg::POS_W;

    typedef struct packed {
        cprc_pkg::t_in_item              it;
        logic [cprc_pkg::SQ_W-1:0]       rem;
        logic [cprc_pkg::ROOT_W-1:0]     root;
    } t_sq;

    logic               f_en;
    logic               r_v0;
    logic               r_v1;
    cprc_pkg::t_in_item r_it0;
    cprc_pkg::t_in_item r_it1;
    logic [2*PW-1:0]    r_sqx;
    logic [2*PW-1:0]    r_sqy;
    logic [STAGES:0]    r_sv;
    t_sq                r_sq [0:STAGES];
    t_sq                n_sq [1:STAGES];
    logic [PW-1:0]      dxm;
    logic [PW-1:0]      dym;

    assign f_en       = !r_sv[STAGES] || i_job_ready;
    assign o_in_ready = f_en;

    always_comb begin
        dxm = (r_it0.first_x >= r_it0.second_x) ? r_it0.first_x - r_it0.second_x
                                                 : r_it0.second_x - r_it0.first_x;
        dym = (r_it0.first_y >= r_it0.second_y) ? r_it0.first_y - r_it0.second_y
                                                 : r_it0.second_y - r_it0.first_y;
    end

    always_comb begin
        logic [TW-1:0] trial;
        int k;
        trial = '0;
        k = 0;
        for (int j = 1; j <= STAGES; j++) begin
            k = STAGES - j;
            n_sq[j] = r_sq[j-1];
            trial = (TW'(r_sq[j-1].root) << (k + 1)) | (TW'(1) << (2 * k));
            if ({1'b0, r_sq[j-1].rem} >= trial) begin
                n_sq[j].rem  = r_sq[j-1].rem - trial[cprc_pkg::SQ_W-1:0];
                n_sq[j].root = r_sq[j-1].root | (cprc_pkg::ROOT_W'(1) << k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_sv <= '0;
        end else if (f_en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_sv <= {r_sv[STAGES-1:0], r_v1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_it0 <= i_in_data;
            r_it1 <= r_it0;
            r_sqx <= dxm * dxm;
            r_sqy <= dym * dym;
            r_sq[0].it   <= r_it1;
            r_sq[0].rem  <= cprc_pkg::SQ_W'(r_sqx) + cprc_pkg::SQ_W'(r_sqy);
            r_sq[0].root <= '0;
            for (int j = 1; j <= STAGES; j++) begin
                r_sq[j] <= n_sq[j];
            end
        end
    end

    always_comb begin
        logic [PW-1:0]               mx;
        logic [PW-1:0]               my;
        logic [cprc_pkg::OV_W-1:0]   rsum;
        cprc_pkg::t_in_item          it;
        it   = r_sq[STAGES].it;
        mx   = (it.first_x >= it.second_x) ? it.first_x - it.second_x
                                           : it.second_x - it.first_x;
        my   = (it.first_y >= it.second_y) ? it.first_y - it.second_y
                                           : it.second_y - it.first_y;
        rsum = cprc_pkg::OV_W'(it.first_radius) + cprc_pkg::OV_W'(it.second_radius);
        o_job.ax   = it.first_x;
        o_job.ay   = it.first_y;
        o_job.bx   = it.second_x;
        o_job.by   = it.second_y;
        o_job.sx   = it.first_x < it.second_x;
        o_job.sy   = it.first_y < it.second_y;
        o_job.mx   = mx[cprc_pkg::OV_W-1:0];
        o_job.my   = my[cprc_pkg::OV_W-1:0];
        o_job.dlen = r_sq[STAGES].root[cprc_pkg::OV_W-1:0];
        o_job.ov   = rsum - r_sq[STAGES].root[cprc_pkg::OV_W-1:0];
        o_job.coin = (it.first_x == it.second_x) && (it.first_y == it.second_y);
        o_job.over = !o_job.coin
                     && (r_sq[STAGES].root < cprc_pkg::ROOT_W'(rsum));
    end

    assign o_job_valid = r_sv[STAGES];

endmodule

// File: rtl/core/cprc_queue.sv
`include "assert_macros.svh"

module cprc_queue #(
    parameter int unsigned DEPTH = cprc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  cprc_pkg::t_job i_push,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output cprc_pkg::t_job o_pop
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cprc_pkg::t_job r_mem [0:DEPTH-1];
    logic [IW-1:0]  r_wr;
    logic [IW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = r_cnt != CW'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push;
        end
    end

    `CPRC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH), "queue count overflow")
    `CPRC_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, push && !pop, r_cnt == CW'($past(r_cnt) + 1'b1), "queue count did not advance")

endmodule

// File: rtl/core/cprc_back.sv
`include "assert_macros.svh"

module cprc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [cprc_pkg::STF_W-1:0]   i_stiffness,
    input  logic                         i_job_valid,
    output logic                         o_job_ready,
    input  cprc_pkg::t_job               i_job,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output cprc_pkg::t_out_item          o_out_data
);

    localparam int unsigned LAST = cprc_pkg::Q_W + 1;
    localparam int unsigned NW   = cprc_pkg::NUM_W;
    localparam int unsigned SW   = cprc_pkg::POS_W + 2;
    localparam int unsigned PW   = cprc_pkg::PROD_W + cprc_pkg::OV_W;

    typedef struct packed {
        cprc_pkg::t_job               job;
        logic [NW-1:0]                nx;
        logic [NW-1:0]                ny;
        logic [cprc_pkg::Q_W-1:0]     qx;
        logic [cprc_pkg::Q_W-1:0]     qy;
    } t_bk;

    logic                        b_en;
    logic [LAST:0]               r_bv;
    t_bk                         r_bk [0:LAST];
    t_bk                         n_bk [1:LAST];
    logic                        r_ov;
    cprc_pkg::t_out_item         r_out;
    cprc_pkg::t_out_item         n_out;
    logic [cprc_pkg::PROD_W-1:0] mx_stf;
    logic [cprc_pkg::PROD_W-1:0] my_stf;
    logic                        both_flags;

    function automatic logic [cprc_pkg::POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic [cprc_pkg::POS_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > SW'(cprc_pkg::POS_MAX)) begin
            r = cprc_pkg::POS_W'(cprc_pkg::POS_MAX);
        end else begin
            r = v[cprc_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    assign b_en        = !r_ov || i_out_ready;
    assign o_job_ready = b_en;
    assign mx_stf      = i_job.mx * i_stiffness;
    assign my_stf      = i_job.my * i_stiffness;

    always_comb begin
        logic [NW-1:0] dsh;
        logic [PW-1:0] prx;
        logic [PW-1:0] pry;
        int k;
        dsh = '0;
        k = 0;
        prx = r_bk[0].nx[cprc_pkg::PROD_W-1:0] * r_bk[0].job.ov;
        pry = r_bk[0].ny[cprc_pkg::PROD_W-1:0] * r_bk[0].job.ov;
        n_bk[1] = r_bk[0];
        if (r_bk[0].job.over) begin
            n_bk[1].nx = NW'(prx) + (NW'(r_bk[0].job.dlen) << 8);
            n_bk[1].ny = NW'(pry) + (NW'(r_bk[0].job.dlen) << 8);
        end else begin
            n_bk[1].nx       = '0;
            n_bk[1].ny       = '0;
            n_bk[1].job.dlen = cprc_pkg::OV_W'(1);
        end
        n_bk[1].qx = '0;
        n_bk[1].qy = '0;
        for (int j = 2; j <= LAST; j++) begin
            k = LAST - j;
            n_bk[j] = r_bk[j-1];
            dsh = NW'(r_bk[j-1].job.dlen) << (k + 9);
            if (r_bk[j-1].nx >= dsh) begin
                n_bk[j].nx = r_bk[j-1].nx - dsh;
                n_bk[j].qx = r_bk[j-1].qx | (cprc_pkg::Q_W'(1) << k);
            end
            if (r_bk[j-1].ny >= dsh) begin
                n_bk[j].ny = r_bk[j-1].ny - dsh;
                n_bk[j].qy = r_bk[j-1].qy | (cprc_pkg::Q_W'(1) << k);
            end
        end
    end

    always_comb begin
        logic signed [SW-1:0] cx;
        logic signed [SW-1:0] cy;
        cprc_pkg::t_job       jb;
        jb = r_bk[LAST].job;
        cx = $signed(SW'(r_bk[LAST].qx));
        cy = $signed(SW'(r_bk[LAST].qy));
        if (jb.sx) begin
            cx = -cx;
        end
        if (jb.sy) begin
            cy = -cy;
        end
        n_out.new_first_x  = sat_pos($signed(SW'(jb.ax)) + cx);
        n_out.new_first_y  = sat_pos($signed(SW'(jb.ay)) + cy);
        n_out.new_second_x = sat_pos($signed(SW'(jb.bx)) - cx);
        n_out.new_second_y = sat_pos($signed(SW'(jb.by)) - cy);
        n_out.overlapped   = jb.over;
        n_out.coincident   = jb.coin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (b_en) begin
            r_bv <= {r_bv[LAST-1:0], i_job_valid};
            r_ov <= r_bv[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_bk[0].job <= i_job;
            r_bk[0].nx  <= NW'(mx_stf);
            r_bk[0].ny  <= NW'(my_stf);
            r_bk[0].qx  <= '0;
            r_bk[0].qy  <= '0;
            for (int j = 1; j <= LAST; j++) begin
                r_bk[j] <= n_bk[j];
            end
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign both_flags  = r_out.overlapped && r_out.coincident;

    `CPRC_ASSERT(a_flags_excl, i_clk, i_rst_n, !(r_ov && both_flags), "both flags set")

endmodule

// File: rtl/core/circle_pair_collision_resolve_core.sv
// Circle pair collision resolver. Each request carries two circles (Q12.8 centers,
// Q8.8 radii); the result gives both centers pushed apart along their difference by
// stiffness times half the overlap, clamped to 20 bits, plus overlap and coincident
// flags. Unless a full queue stalls the front, one request per cycle enters the
// pipelined square root (one root bit per stage, 21 stages) in the front and the
// pipelined divider (one quotient bit per stage, 17 stages) in the back. A short
// queue between them lets the front keep taking requests while the output stalls.
// Write stiffness (Q0.8, reset 51) on the config channel only while idle.
module circle_pair_collision_resolve_core #(
    parameter int unsigned QUEUE_DEPTH = cprc_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  cprc_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output cprc_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cprc_pkg::STF_W-1:0]   i_cfg_data
);

    logic [cprc_pkg::STF_W-1:0] r_stiffness;
    logic                       fq_valid;
    logic                       fq_ready;
    cprc_pkg::t_job             fq_job;
    logic                       qb_valid;
    logic                       qb_ready;
    cprc_pkg::t_job             qb_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= cprc_pkg::STF_W'(cprc_pkg::STF_RESET);
        end else if (i_cfg_valid) begin
            r_stiffness <= i_cfg_data;
        end
    end

    cprc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    cprc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push       (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop        (qb_job)
    );

    cprc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stiffness (r_stiffness),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job       (qb_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
